[rtl/one_wire_bus_master_unit_assert.svh]
// Assertion macros for the checker of the one-wire bus master.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OWBM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("one-wire master check failed");

// The consequent must hold in the cycle after the antecedent.
`define OWBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("one-wire master check failed");

`endif

[rtl/owbm_pkg.sv]
package owbm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_INDEX_W   = 3;
    localparam int CFG_W         = 10;
    localparam int CFG_COUNT     = 8;
    localparam int CFG_INDEX_W   = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_RECOVER = 3'd2,
        REG_WRITE_ONE_LOW = 3'd3,
        REG_WRITE_ZERO_LOW = 3'd4,
        REG_SLOT          = 3'd5,
        REG_READ_LOW      = 3'd6,
        REG_READ_SAMPLE   = 3'd7
    } cfg_index_t;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_COUNT] = '{
        10'd480, 10'd70, 10'd410, 10'd6, 10'd60, 10'd70, 10'd6, 10'd15
    };

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        PH_IDLE        = 6'b000001,
        PH_RST_LOW     = 6'b000010,
        PH_RST_WAIT    = 6'b000100,
        PH_RST_RECOVER = 6'b001000,
        PH_WRITE       = 6'b010000,
        PH_READ        = 6'b100000
    } phase_t;

    // One result word as it sits in the output stage.
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       presence_level;
    } result_t;

    // A duration of zero counts as one tick.
    function automatic logic [CFG_W-1:0] seg_len(input logic [CFG_W-1:0] v);
        seg_len = (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage

[rtl/one_wire_bus_master_unit.sv]
// One-wire bus master timing sequencer. Each input word is one microsecond tick carrying an
// optional command (reset pulse, write byte, read byte), the byte to send and the sampled bus
// level; each accepted word yields exactly one result word with the bus drive for that tick,
// busy, a done pulse on the last tick of a command, the byte of the last completed read and the
// presence level of the last reset. A command is taken only while the sequencer is idle; while
// busy the operation field is ignored. Bytes go out and come in LSB first, one slot per bit.
// Throughput is one word per clock cycle unless stalled: the whole sequencer step (segment
// counter compare, bit index and shift register update) is one combinational pass from the
// state registers into the result register. A two-entry output stage (result register plus a
// skid register) lets the block keep taking ticks while a result waits; in_stall is raised only
// when both entries are full. Durations come from eight 10-bit registers written through the
// cfg_we/cfg_index/cfg_data port, which should only be written while the block is idle.
module one_wire_bus_master_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [7:0]                         data_byte,
    input  logic                               line_level,
    // Output channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               drive_low,
    output logic                               busy_res,
    output logic                               done_res,
    output logic [7:0]                         read_byte,
    output logic                               presence_level,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]         cfg_data
);

    // Configuration registers.
    logic [owbm_pkg::CFG_W-1:0] cfg_reg [owbm_pkg::CFG_COUNT];

    // Sequencer state.
    owbm_pkg::phase_t                  phase_reg, phase_next;
    logic [owbm_pkg::CFG_W-1:0]        tick_count_reg, tick_count_next;
    logic [owbm_pkg::BIT_INDEX_W-1:0]  bit_index_reg, bit_index_next;
    logic [7:0]                        shift_byte_reg, shift_byte_next;
    logic                              presence_flag_reg, presence_flag_next;
    logic [7:0]                        last_read_reg, last_read_next;

    // Output stage.
    owbm_pkg::result_t out_reg, skid_reg, result;
    logic              out_valid_reg, skid_valid_reg;

    // State after a possible command start on this tick.
    owbm_pkg::phase_t                  phase_eff;
    logic [owbm_pkg::CFG_W-1:0]        tc_eff;
    logic [owbm_pkg::BIT_INDEX_W-1:0]  bi_eff;
    logic [7:0]                        sh_eff;
    logic [7:0]                        sh_read;
    logic [owbm_pkg::CFG_W:0]          tc_plus;
    logic [owbm_pkg::CFG_W-1:0]        slot_len;
    logic [owbm_pkg::CFG_W-1:0]        low_len;
    logic [owbm_pkg::CFG_W-1:0]        sample_pt;
    logic                              slot_end;
    logic                              last_bit;
    logic                              drive, busy, done;
    logic                              in_accept;
    owbm_pkg::op_t                     op_in;

    assign op_in     = owbm_pkg::op_t'(operation);
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < owbm_pkg::CFG_COUNT; i++)
            begin
                cfg_reg[i] <= owbm_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        phase_eff = phase_reg;
        tc_eff    = tick_count_reg;
        bi_eff    = bit_index_reg;
        sh_eff    = shift_byte_reg;
        if (phase_reg == owbm_pkg::PH_IDLE && op_in != owbm_pkg::OP_NONE)
        begin
            tc_eff = '0;
            bi_eff = '0;
            unique case (op_in)
                owbm_pkg::OP_RESET: phase_eff = owbm_pkg::PH_RST_LOW;
                owbm_pkg::OP_WRITE: phase_eff = owbm_pkg::PH_WRITE;
                default:            phase_eff = owbm_pkg::PH_READ;
            endcase
            sh_eff = (op_in == owbm_pkg::OP_WRITE) ? data_byte : 8'd0;
        end
    end

    always_comb
    begin
        tc_plus  = {1'b0, tc_eff} + 11'd1;
        slot_len = owbm_pkg::seg_len(cfg_reg[owbm_pkg::REG_SLOT]);
        slot_end = tc_plus >= {1'b0, slot_len};
        last_bit = ({1'b0, bi_eff} + 4'd1) >= 4'(owbm_pkg::BITS_PER_BYTE);
        low_len  = sh_eff[0] ? cfg_reg[owbm_pkg::REG_WRITE_ONE_LOW]
                             : cfg_reg[owbm_pkg::REG_WRITE_ZERO_LOW];
        // A sample offset at or past the slot end falls on the last tick of the slot.
        sample_pt = (cfg_reg[owbm_pkg::REG_READ_SAMPLE] < slot_len)
                  ? cfg_reg[owbm_pkg::REG_READ_SAMPLE] : slot_len - 10'd1;
        sh_read = sh_eff;
        if (tc_eff == sample_pt)
        begin
            sh_read = (sh_eff >> 1)
                    | (8'({7'd0, line_level}) << (owbm_pkg::BITS_PER_BYTE - 1));
        end
    end

    always_comb
    begin
        phase_next         = phase_eff;
        tick_count_next    = tc_plus[owbm_pkg::CFG_W-1:0];
        bit_index_next     = bi_eff;
        shift_byte_next    = sh_eff;
        presence_flag_next = presence_flag_reg;
        last_read_next     = last_read_reg;
        drive              = 1'b0;
        busy               = 1'b0;
        done               = 1'b0;
        unique case (phase_eff)
            owbm_pkg::PH_RST_LOW:
            begin
                busy  = 1'b1;
                drive = 1'b1;
                if (tc_plus >= {1'b0, owbm_pkg::seg_len(cfg_reg[owbm_pkg::REG_RESET_LOW])})
                begin
                    phase_next      = owbm_pkg::PH_RST_WAIT;
                    tick_count_next = '0;
                end
            end
            owbm_pkg::PH_RST_WAIT:
            begin
                busy = 1'b1;
                if (tc_plus >= {1'b0,
                        owbm_pkg::seg_len(cfg_reg[owbm_pkg::REG_PRESENCE_WAIT])})
                begin
                    phase_next      = owbm_pkg::PH_RST_RECOVER;
                    tick_count_next = '0;
                end
            end
            owbm_pkg::PH_RST_RECOVER:
            begin
                busy = 1'b1;
                // The presence sample is taken on the first tick of recovery.
                if (tc_eff == '0)
                begin
                    presence_flag_next = line_level;
                end
                if (tc_plus >= {1'b0,
                        owbm_pkg::seg_len(cfg_reg[owbm_pkg::REG_RESET_RECOVER])})
                begin
                    phase_next      = owbm_pkg::PH_IDLE;
                    tick_count_next = '0;
                    done            = 1'b1;
                end
            end
            owbm_pkg::PH_WRITE:
            begin
                busy  = 1'b1;
                drive = tc_eff < low_len;
                if (slot_end)
                begin
                    shift_byte_next = sh_eff >> 1;
                    tick_count_next = '0;
                    if (last_bit)
                    begin
                        phase_next     = owbm_pkg::PH_IDLE;
                        bit_index_next = '0;
                        done           = 1'b1;
                    end
                    else
                    begin
                        bit_index_next = bi_eff + 3'd1;
                    end
                end
            end
            owbm_pkg::PH_READ:
            begin
                busy            = 1'b1;
                drive           = tc_eff < cfg_reg[owbm_pkg::REG_READ_LOW];
                shift_byte_next = sh_read;
                if (slot_end)
                begin
                    tick_count_next = '0;
                    if (last_bit)
                    begin
                        phase_next     = owbm_pkg::PH_IDLE;
                        bit_index_next = '0;
                        done           = 1'b1;
                        last_read_next = sh_read;
                    end
                    else
                    begin
                        bit_index_next = bi_eff + 3'd1;
                    end
                end
            end
            default:
            begin
                phase_next      = owbm_pkg::PH_IDLE;
                tick_count_next = '0;
            end
        endcase
    end

    always_comb
    begin
        result.drive_low      = drive;
        result.busy_res       = busy;
        result.done_res       = done;
        result.read_byte      = last_read_next;
        result.presence_level = presence_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= owbm_pkg::PH_IDLE;
            tick_count_reg    <= '0;
            bit_index_reg     <= '0;
            shift_byte_reg    <= '0;
            presence_flag_reg <= 1'b1;
            last_read_reg     <= '0;
        end
        else if (in_accept)
        begin
            phase_reg         <= phase_next;
            tick_count_reg    <= tick_count_next;
            bit_index_reg     <= bit_index_next;
            shift_byte_reg    <= shift_byte_next;
            presence_flag_reg <= presence_flag_next;
            last_read_reg     <= last_read_next;
        end
    end

    // The result register refills from the skid register first, so word order is kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg  <= skid_valid_reg || in_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (in_accept)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_low      = out_reg.drive_low;
    assign busy_res       = out_reg.busy_res;
    assign done_res       = out_reg.done_res;
    assign read_byte      = out_reg.read_byte;
    assign presence_level = out_reg.presence_level;

endmodule

[rtl/owbm_checker.sv]
`include "one_wire_bus_master_unit_assert.svh"

module owbm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       drive_low,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] read_byte,
    input logic       presence_level
);

    logic [11:0] out_word;

    assign out_word = {drive_low, busy_res, done_res, read_byte, presence_level};

    // A stalled result word stays valid and unchanged.
    `OWBM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    // The input side only stalls after a result word was held up downstream.
    `OWBM_ASSERT_SAME(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall))

    // The done pulse falls on a tick that still belongs to the command.
    `OWBM_ASSERT_SAME(a_done_busy, out_valid && done_res, busy_res)

    // The bus is only pulled low while a command runs.
    `OWBM_ASSERT_SAME(a_drive_busy, out_valid && drive_low, busy_res)

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (.*);

[test/one_wire_bus_master_unit_tb.sv]
module one_wire_bus_master_unit_tb;

    // The cycle limit is far above the slowest correct run, even with the worst stall and gap
    // patterns plus the long hold-off.
    localparam int CYCLE_LIMIT = 200_000;
    // Length of the single long output hold-off, in cycles.
    localparam int LONG_HOLD = 400;
    // Number of random phases, and the ticks offered in each of them.
    localparam int RANDOM_PHASES = 4;
    localparam int TICKS_PER_PHASE = 190;

    // Tracks the sequencer tick by tick. Every accepted input word yields one expected result
    // word, and those words are matched in order against what leaves the block.
    class tick_scoreboard;
        logic [owbm_pkg::CFG_W-1:0] dur [owbm_pkg::CFG_COUNT];
        owbm_pkg::phase_t           phase;
        logic [owbm_pkg::CFG_W-1:0] tick_count;
        int                         bit_index;
        logic [7:0]                 shift_byte;
        logic                       presence;
        logic [7:0]                 last_read;
        owbm_pkg::result_t          pending_results [$];
        int                         errors;

        function new();
            foreach (dur[i])
                dur[i] = owbm_pkg::CFG_RESET[i];
            phase      = owbm_pkg::PH_IDLE;
            tick_count = '0;
            bit_index  = 0;
            shift_byte = '0;
            presence   = 1'b1;
            last_read  = '0;
            errors     = 0;
        endfunction

        function void set_reg(owbm_pkg::cfg_index_t idx, logic [owbm_pkg::CFG_W-1:0] val);
            dur[idx] = val;
        endfunction

        function bit idle();
            return phase == owbm_pkg::PH_IDLE;
        endfunction

        // A duration register of zero still lasts one tick.
        function int at_least_one(logic [owbm_pkg::CFG_W-1:0] v);
            return (v == '0) ? 1 : int'(v);
        endfunction

        // Closes a bit slot. Returns 1 when the last bit of the byte has been handled.
        function bit end_of_slot();
            tick_count = '0;
            if (bit_index + 1 >= owbm_pkg::BITS_PER_BYTE) begin
                phase     = owbm_pkg::PH_IDLE;
                bit_index = 0;
                return 1'b1;
            end
            bit_index = bit_index + 1;
            return 1'b0;
        endfunction

        function void take_tick(owbm_pkg::op_t op, logic [7:0] data, logic line);
            owbm_pkg::result_t r;
            int                slot;
            int                low;
            int                sample_at;
            r    = '0;
            slot = at_least_one(dur[owbm_pkg::REG_SLOT]);
            if (phase == owbm_pkg::PH_IDLE && op != owbm_pkg::OP_NONE) begin
                tick_count = '0;
                bit_index  = 0;
                case (op)
                    owbm_pkg::OP_RESET: phase = owbm_pkg::PH_RST_LOW;
                    owbm_pkg::OP_WRITE: phase = owbm_pkg::PH_WRITE;
                    default:            phase = owbm_pkg::PH_READ;
                endcase
                shift_byte = (op == owbm_pkg::OP_WRITE) ? data : 8'h00;
            end
            case (phase)
                owbm_pkg::PH_RST_LOW:
                begin
                    r.busy_res  = 1'b1;
                    r.drive_low = 1'b1;
                    if (int'(tick_count) + 1 >=
                            at_least_one(dur[owbm_pkg::REG_RESET_LOW])) begin
                        phase      = owbm_pkg::PH_RST_WAIT;
                        tick_count = '0;
                    end
                    else
                        tick_count++;
                end
                owbm_pkg::PH_RST_WAIT:
                begin
                    r.busy_res = 1'b1;
                    if (int'(tick_count) + 1 >=
                            at_least_one(dur[owbm_pkg::REG_PRESENCE_WAIT])) begin
                        phase      = owbm_pkg::PH_RST_RECOVER;
                        tick_count = '0;
                    end
                    else
                        tick_count++;
                end
                owbm_pkg::PH_RST_RECOVER:
                begin
                    r.busy_res = 1'b1;
                    if (tick_count == '0)
                        presence = line;
                    if (int'(tick_count) + 1 >=
                            at_least_one(dur[owbm_pkg::REG_RESET_RECOVER])) begin
                        phase      = owbm_pkg::PH_IDLE;
                        tick_count = '0;
                        r.done_res = 1'b1;
                    end
                    else
                        tick_count++;
                end
                owbm_pkg::PH_WRITE:
                begin
                    low = shift_byte[0] ? int'(dur[owbm_pkg::REG_WRITE_ONE_LOW])
                                        : int'(dur[owbm_pkg::REG_WRITE_ZERO_LOW]);
                    r.busy_res  = 1'b1;
                    r.drive_low = (int'(tick_count) < low);
                    if (int'(tick_count) + 1 >= slot) begin
                        shift_byte = shift_byte >> 1;
                        if (end_of_slot())
                            r.done_res = 1'b1;
                    end
                    else
                        tick_count++;
                end
                owbm_pkg::PH_READ:
                begin
                    // A sample point past the slot end falls on the last tick of the slot.
                    sample_at = (int'(dur[owbm_pkg::REG_READ_SAMPLE]) < slot)
                              ? int'(dur[owbm_pkg::REG_READ_SAMPLE]) : slot - 1;
                    r.busy_res  = 1'b1;
                    r.drive_low = (int'(tick_count) < int'(dur[owbm_pkg::REG_READ_LOW]));
                    if (int'(tick_count) == sample_at)
                        shift_byte = (shift_byte >> 1)
                                   | (8'(line) << (owbm_pkg::BITS_PER_BYTE - 1));
                    if (int'(tick_count) + 1 >= slot) begin
                        if (end_of_slot()) begin
                            r.done_res = 1'b1;
                            last_read  = shift_byte;
                        end
                    end
                    else
                        tick_count++;
                end
                default:
                begin
                    phase      = owbm_pkg::PH_IDLE;
                    tick_count = '0;
                end
            endcase
            r.read_byte      = last_read;
            r.presence_level = presence;
            pending_results.push_back(r);
        endfunction

        function void match_result(owbm_pkg::result_t got);
            owbm_pkg::result_t want;
            if (pending_results.size() == 0) begin
                $error("result word arrived with no tick outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.drive_low !== want.drive_low) begin
                $error("drive_low: expected %0d, actual %0d", want.drive_low, got.drive_low);
                errors++;
            end
            if (got.busy_res !== want.busy_res) begin
                $error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
                errors++;
            end
            if (got.done_res !== want.done_res) begin
                $error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
                errors++;
            end
            if (got.read_byte !== want.read_byte) begin
                $error("read_byte: expected %0h, actual %0h", want.read_byte, got.read_byte);
                errors++;
            end
            if (got.presence_level !== want.presence_level) begin
                $error("presence_level: expected %0d, actual %0d",
                       want.presence_level, got.presence_level);
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [1:0]                       operation;
    logic [7:0]                       data_byte;
    logic                             line_level;
    logic                             out_valid;
    logic                             out_stall;
    logic                             drive_low;
    logic                             busy_res;
    logic                             done_res;
    logic [7:0]                       read_byte;
    logic                             presence_level;
    logic                             cfg_we;
    logic [owbm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [owbm_pkg::CFG_W-1:0]       cfg_data;

    tick_scoreboard             sb;
    logic [owbm_pkg::CFG_W-1:0] plan [owbm_pkg::CFG_COUNT];
    int                         burst_left;
    int                         cycle_count;
    // Set by the stimulus thread when the long output hold-off should happen.
    bit                         hold_armed;

    one_wire_bus_master_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .data_byte      (data_byte),
        .line_level     (line_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .read_byte      (read_byte),
        .presence_level (presence_level),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Puts one tick word on the input channel at a falling edge and holds it until a rising
    // edge finds the block not stalling. The predictor advances at that same edge.
    task automatic send_tick(owbm_pkg::op_t op, logic [7:0] data, logic line);
        @(negedge clk);
        in_valid   <= 1'b1;
        operation  <= op;
        data_byte  <= data;
        line_level <= line;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_tick(op, data, line);
    endtask

    // Keeps the input channel empty for a pause whose length is given by n.
    task automatic pause(int n);
        if (n > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Every tick goes through here, so the sender works in bursts of random length with random
    // gaps no matter which part of the command the block is in. Some bursts are long, giving
    // stretches with no idling at all.
    task automatic offer(owbm_pkg::op_t op, logic [7:0] data, logic line);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
            pause($urandom_range(0, 6));
        end
        burst_left--;
        send_tick(op, data, line);
    endtask

    // While a command runs the operation field is ignored, so random operations there are
    // harmless noise. Data and bus level are random too, which feeds presence and read bits.
    task automatic finish_command();
        while (!sb.idle())
            offer(owbm_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic issue(owbm_pkg::op_t op, logic [7:0] data);
        offer(op, data, 1'($urandom_range(0, 1)));
        finish_command();
    endtask

    // Brings the block to rest: the running command ends, the input goes quiet and every
    // expected result word has come out. Each tick gives a result, so nothing is left inside.
    task automatic quiesce();
        finish_command();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all eight duration registers from plan, one per cycle.
    task automatic apply_plan();
        foreach (plan[i]) begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= owbm_pkg::cfg_index_t'(i);
            cfg_data  <= plan[i];
            sb.set_reg(owbm_pkg::cfg_index_t'(i), plan[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly short durations so commands finish fast. Zero shows up on its own, and the
    // low-pulse and sample registers sometimes go to the top of their range, which gives
    // long low pulses and late samples without slowing the run.
    task automatic pick_random_plan();
        foreach (plan[i]) begin
            case ($urandom_range(0, 9))
                0: plan[i] = '0;
                1:
                begin
                    if (i == owbm_pkg::REG_WRITE_ONE_LOW || i == owbm_pkg::REG_WRITE_ZERO_LOW ||
                        i == owbm_pkg::REG_READ_LOW || i == owbm_pkg::REG_READ_SAMPLE)
                        plan[i] = 10'd1023;
                    else
                        plan[i] = 10'd1;
                end
                default: plan[i] = owbm_pkg::CFG_W'($urandom_range(1, 12));
            endcase
        end
    endtask

    // From idle most ticks start a command; the rest leave the block idle for a while.
    task automatic random_tick();
        owbm_pkg::op_t op;
        if (sb.idle())
            op = ($urandom_range(0, 99) < 30) ? owbm_pkg::OP_NONE
                                               : owbm_pkg::op_t'($urandom_range(1, 3));
        else
            op = owbm_pkg::op_t'($urandom_range(0, 3));
        offer(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Receiver: stalls on a pattern of its own. Each stretch picks a stall rate, zero among
    // them. Once armed, it holds off for a long count of cycles so that both output entries
    // fill and the block stalls its input while the sender keeps offering.
    initial begin
        int stall_pct;
        int stretch_left;
        int hold_left;
        bit hold_taken;
        stall_pct    = 0;
        stretch_left = 0;
        hold_left    = 0;
        hold_taken   = 1'b0;
        out_stall    = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_armed && !hold_taken && hold_left == 0)
                hold_left = LONG_HOLD;
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
                if (hold_left == 0)
                    hold_taken = 1'b1;
            end
            else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(10, 150);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 75;
                    endcase
                end
                stretch_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Result monitor: a word is taken at a rising edge with valid high and stall low.
    initial begin
        owbm_pkg::result_t got;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got = {drive_low, busy_res, done_res, read_byte, presence_level};
                sb.match_result(got);
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk) cycle_count++;
        $display("status: fail");
        $finish;
    end

    initial begin
        sb         = new();
        burst_left = 0;
        hold_armed = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = owbm_pkg::OP_NONE;
        data_byte  = 8'h00;
        line_level = 1'b1;
        cfg_we     = 1'b0;
        cfg_index  = owbm_pkg::REG_RESET_LOW;
        cfg_data   = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Durations as they come out of reset: one full read at bus timing.
        offer(owbm_pkg::OP_NONE, 8'h00, 1'b1);
        issue(owbm_pkg::OP_READ, 8'h00);
        quiesce();

        // Every register at zero: each segment shrinks to one tick and only the reset drives the bus low.
        foreach (plan[i])
            plan[i] = '0;
        apply_plan();
        offer(owbm_pkg::OP_NONE, 8'hFF, 1'b0);
        issue(owbm_pkg::OP_RESET, 8'h00);
        issue(owbm_pkg::OP_WRITE, 8'h00);
        issue(owbm_pkg::OP_WRITE, 8'hFF);
        issue(owbm_pkg::OP_READ, 8'h00);
        issue(owbm_pkg::OP_READ, 8'hFF);
        quiesce();

        // A slot of two ticks with low pulses that cover it, and a sample point far past its end.
        plan[owbm_pkg::REG_RESET_LOW]      = 10'd1;
        plan[owbm_pkg::REG_PRESENCE_WAIT]  = 10'd1;
        plan[owbm_pkg::REG_RESET_RECOVER]  = 10'd1;
        plan[owbm_pkg::REG_WRITE_ONE_LOW]  = 10'd1023;
        plan[owbm_pkg::REG_WRITE_ZERO_LOW] = 10'd1023;
        plan[owbm_pkg::REG_SLOT]           = 10'd2;
        plan[owbm_pkg::REG_READ_LOW]       = 10'd1023;
        plan[owbm_pkg::REG_READ_SAMPLE]    = 10'd1023;
        apply_plan();
        issue(owbm_pkg::OP_WRITE, 8'hA5);
        issue(owbm_pkg::OP_READ, 8'h00);
        issue(owbm_pkg::OP_RESET, 8'h00);
        quiesce();

        // A one bit with no low pulse, a zero bit low for the whole slot, and a read sample
        // taken while the master itself still holds the bus low.
        plan[owbm_pkg::REG_RESET_LOW]      = 10'd2;
        plan[owbm_pkg::REG_PRESENCE_WAIT]  = 10'd1;
        plan[owbm_pkg::REG_RESET_RECOVER]  = 10'd3;
        plan[owbm_pkg::REG_WRITE_ONE_LOW]  = 10'd0;
        plan[owbm_pkg::REG_WRITE_ZERO_LOW] = 10'd4;
        plan[owbm_pkg::REG_SLOT]           = 10'd4;
        plan[owbm_pkg::REG_READ_LOW]       = 10'd3;
        plan[owbm_pkg::REG_READ_SAMPLE]    = 10'd0;
        apply_plan();
        issue(owbm_pkg::OP_WRITE, 8'h5A);
        issue(owbm_pkg::OP_READ, 8'h00);
        issue(owbm_pkg::OP_RESET, 8'h00);
        quiesce();

        // Random settings, each with a stretch of random ticks. The long output hold-off
        // happens during the second of them.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick_random_plan();
            apply_plan();
            if (ph == 1)
                hold_armed = 1'b1;
            repeat (TICKS_PER_PHASE) random_tick();
            quiesce();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.pending_results.size() != 0)
            $error("%0d result words never arrived", sb.pending_results.size());
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[one_wire_bus_master_unit.f]
+incdir+rtl
rtl/owbm_pkg.sv
rtl/one_wire_bus_master_unit.sv
rtl/owbm_checker.sv
test/one_wire_bus_master_unit_tb.sv
